// ===== src/mdist_pkg.sv =====
// Shared widths, codes and bundle types for the 3D Mahalanobis distance unit.
// No dependencies; every other file in src imports this package.
package mdist_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = WORD_W / 2;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int COF_W     = 2 * WORD_W + 1;
	localparam int DET_W     = 3 * WORD_W + 3;
	localparam int Q_W       = 4 * WORD_W + 3;
	localparam int NH_W      = Q_W - 2 * WORD_W + FRAC_W;
	localparam int NUM_TERMS = 6;
	localparam int IDX_W     = 3;
	localparam int BIT_W     = $clog2(WORD_W);

	// Determinant threshold: det * 1e10 <= 2^(3*FRAC_W)  <=>  det <= DET_MIN
	localparam logic [DET_W-1:0] DET_MIN =
		(DET_W'(1) << (3 * FRAC_W)) / DET_W'(34'd10000000000);

	localparam logic [WORD_W-1:0] COV_ONE = WORD_W'(1) << FRAC_W;

	typedef enum logic [IDX_W-1:0] {
		REG_VAR_X  = 3'd0,
		REG_COV_XY = 3'd1,
		REG_COV_XZ = 3'd2,
		REG_VAR_Y  = 3'd3,
		REG_COV_YZ = 3'd4,
		REG_VAR_Z  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DET_SMALL = 2'd1,
		ST_VAR_X     = 2'd2,
		ST_MINOR     = 2'd3
	} status_t;

	// Per-request control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic neg;
		logic sat;
	} side_t;

	// Cofactors in order c11, c12, c13, c22, c23, c33
	typedef logic [NUM_TERMS-1:0][COF_W-1:0] cof_vec_t;

	typedef struct packed {
		logic             busy;
		status_t          status;
		logic [DET_W-1:0] det;
		cof_vec_t         cof;
	} cov_t;

endpackage

// ===== src/mdist_cov_solver.sv =====
// Covariance registers plus a bit-serial multiply-accumulate sequencer that
// derives the cofactors, determinant and status. Depends on mdist_pkg.
module mdist_cov_solver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mdist_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mdist_pkg::WORD_W-1:0]     cfg_data,
	output mdist_pkg::cov_t                  cov
);
	import mdist_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_MAC, S_CHECK} state_t;
	typedef enum logic [3:0] {X_A, X_B, X_C, X_D, X_E, X_F, X_C11, X_C12, X_C13} xsel_t;
	typedef enum logic [2:0] {D_NONE, D_C11, D_C12, D_C13, D_C22, D_C23, D_C33, D_DET} dest_t;

	typedef struct packed {
		xsel_t    x;
		reg_idx_t y;
		logic     neg;
		logic     clr;
		dest_t    dest;
	} op_t;

	localparam int               NUM_STEPS = 15;
	localparam logic [3:0]       LAST_STEP = 4'(NUM_STEPS - 1);
	localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(WORD_W - 1);

	function automatic op_t step_op(input logic [3:0] s);
		op_t o;
		o = '{x: X_A, y: REG_VAR_X, neg: 1'b0, clr: 1'b0, dest: D_NONE};
		unique case (s)
			4'd0:  o = '{x: X_D,   y: REG_VAR_Z,  neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd1:  o = '{x: X_E,   y: REG_COV_YZ, neg: 1'b1, clr: 1'b0, dest: D_C11};
			4'd2:  o = '{x: X_C,   y: REG_COV_YZ, neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd3:  o = '{x: X_B,   y: REG_VAR_Z,  neg: 1'b1, clr: 1'b0, dest: D_C12};
			4'd4:  o = '{x: X_B,   y: REG_COV_YZ, neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd5:  o = '{x: X_C,   y: REG_VAR_Y,  neg: 1'b1, clr: 1'b0, dest: D_C13};
			4'd6:  o = '{x: X_A,   y: REG_VAR_Z,  neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd7:  o = '{x: X_C,   y: REG_COV_XZ, neg: 1'b1, clr: 1'b0, dest: D_C22};
			4'd8:  o = '{x: X_B,   y: REG_COV_XZ, neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd9:  o = '{x: X_A,   y: REG_COV_YZ, neg: 1'b1, clr: 1'b0, dest: D_C23};
			4'd10: o = '{x: X_A,   y: REG_VAR_Y,  neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd11: o = '{x: X_B,   y: REG_COV_XY, neg: 1'b1, clr: 1'b0, dest: D_C33};
			4'd12: o = '{x: X_C11, y: REG_VAR_X,  neg: 1'b0, clr: 1'b1, dest: D_NONE};
			4'd13: o = '{x: X_C12, y: REG_COV_XY, neg: 1'b0, clr: 1'b0, dest: D_NONE};
			4'd14: o = '{x: X_C13, y: REG_COV_XZ, neg: 1'b0, clr: 1'b0, dest: D_DET};
			default: o = '{x: X_A, y: REG_VAR_X, neg: 1'b0, clr: 1'b0, dest: D_NONE};
		endcase
		return o;
	endfunction

	function automatic logic [DET_W-1:0] sx_word(input logic [WORD_W-1:0] w);
		return {{(DET_W - WORD_W){w[WORD_W-1]}}, w};
	endfunction

	function automatic logic [DET_W-1:0] sx_cof(input logic [COF_W-1:0] c);
		return {{(DET_W - COF_W){c[COF_W-1]}}, c};
	endfunction

	state_t             state_q;
	logic [3:0]         step_q;
	logic [BIT_W-1:0]   bit_q;
	logic [WORD_W-1:0]  var_x_q, cov_xy_q, cov_xz_q, var_y_q, cov_yz_q, var_z_q;
	logic [DET_W-1:0]   acc_q, xs_q, det_q;
	logic [WORD_W-1:0]  ys_q;
	cof_vec_t           cof_q;
	status_t            status_q;

	op_t                op;
	logic [DET_W-1:0]   xop, pp, acc_nx;
	logic [WORD_W-1:0]  yop;
	logic               sub;
	status_t            chk_status;

	always_comb begin
		op = step_op(step_q);
		unique case (op.x)
			X_A:     xop = sx_word(var_x_q);
			X_B:     xop = sx_word(cov_xy_q);
			X_C:     xop = sx_word(cov_xz_q);
			X_D:     xop = sx_word(var_y_q);
			X_E:     xop = sx_word(cov_yz_q);
			X_F:     xop = sx_word(var_z_q);
			X_C11:   xop = sx_cof(cof_q[0]);
			X_C12:   xop = sx_cof(cof_q[1]);
			X_C13:   xop = sx_cof(cof_q[2]);
			default: xop = '0;
		endcase
		unique case (op.y)
			REG_VAR_X:  yop = var_x_q;
			REG_COV_XY: yop = cov_xy_q;
			REG_COV_XZ: yop = cov_xz_q;
			REG_VAR_Y:  yop = var_y_q;
			REG_COV_YZ: yop = cov_yz_q;
			REG_VAR_Z:  yop = var_z_q;
			default:    yop = '0;
		endcase
		// top multiplier bit carries negative weight
		pp     = ys_q[0] ? xs_q : '0;
		sub    = op.neg ^ (bit_q == LAST_BIT);
		acc_nx = sub ? acc_q - pp : acc_q + pp;

		priority if ($signed(det_q) <= $signed(DET_MIN))
			chk_status = ST_DET_SMALL;
		else if ($signed(var_x_q) <= 0)
			chk_status = ST_VAR_X;
		else if ($signed(cof_q[5]) <= 0)
			chk_status = ST_MINOR;
		else
			chk_status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			step_q   <= '0;
			bit_q    <= '0;
			var_x_q  <= COV_ONE;
			cov_xy_q <= '0;
			cov_xz_q <= '0;
			var_y_q  <= COV_ONE;
			cov_yz_q <= '0;
			var_z_q  <= COV_ONE;
			acc_q    <= '0;
			xs_q     <= '0;
			ys_q     <= '0;
			det_q    <= '0;
			cof_q    <= '0;
			status_q <= ST_OK;
		end else begin
			// a register write restarts the derivation from the first step
			if (cfg_valid && cfg_index <= REG_VAR_Z) begin
				state_q <= S_LOAD;
				step_q  <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
					end
					S_LOAD: begin
						xs_q  <= xop;
						ys_q  <= yop;
						bit_q <= '0;
						if (op.clr)
							acc_q <= '0;
						state_q <= S_MAC;
					end
					S_MAC: begin
						acc_q <= acc_nx;
						xs_q  <= xs_q << 1;
						ys_q  <= ys_q >> 1;
						bit_q <= bit_q + 1'b1;
						if (bit_q == LAST_BIT) begin
							unique case (op.dest)
								D_NONE: begin
								end
								D_C11: cof_q[0] <= acc_nx[COF_W-1:0];
								D_C12: cof_q[1] <= acc_nx[COF_W-1:0];
								D_C13: cof_q[2] <= acc_nx[COF_W-1:0];
								D_C22: cof_q[3] <= acc_nx[COF_W-1:0];
								D_C23: cof_q[4] <= acc_nx[COF_W-1:0];
								D_C33: cof_q[5] <= acc_nx[COF_W-1:0];
								D_DET: det_q    <= acc_nx;
								default: begin
								end
							endcase
							if (step_q == LAST_STEP) begin
								state_q <= S_CHECK;
							end else begin
								step_q  <= step_q + 1'b1;
								state_q <= S_LOAD;
							end
						end
					end
					S_CHECK: begin
						status_q <= chk_status;
						state_q  <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_VAR_X:  var_x_q  <= cfg_data;
					REG_COV_XY: cov_xy_q <= cfg_data;
					REG_COV_XZ: cov_xz_q <= cfg_data;
					REG_VAR_Y:  var_y_q  <= cfg_data;
					REG_COV_YZ: cov_yz_q <= cfg_data;
					REG_VAR_Z:  var_z_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg_ready  = 1'b1;
	assign cov.busy   = (state_q != S_IDLE);
	assign cov.status = status_q;
	assign cov.det    = det_q;
	assign cov.cof    = cof_q;

endmodule

// ===== src/mdist_quad_form.sv =====
// Five-stage pipeline for the quadratic form d' adj(S) d out of 33x33 partial
// products. Depends on mdist_pkg.
module mdist_quad_form (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  mdist_pkg::side_t                  side_in,
	input  logic signed [mdist_pkg::WORD_W-1:0] dx,
	input  logic signed [mdist_pkg::WORD_W-1:0] dy,
	input  logic signed [mdist_pkg::WORD_W-1:0] dz,
	input  mdist_pkg::cof_vec_t               cof,
	output logic [mdist_pkg::Q_W-1:0]         q,
	output mdist_pkg::side_t                  side_out
);
	import mdist_pkg::*;

	localparam int PP_W = 2 * WORD_W + 2;
	// off-diagonal terms xy, xz, yz count twice
	localparam logic [NUM_TERMS-1:0] TERM_DOUBLE = 6'b010110;

	logic signed [PROD_W-1:0] prod_s1 [NUM_TERMS];
	logic [PROD_W-1:0]        pp_ll_s2 [NUM_TERMS];
	logic signed [PP_W-1:0]   pp_lh_s2 [NUM_TERMS];
	logic signed [PP_W-1:0]   pp_hl_s2 [NUM_TERMS];
	logic signed [PP_W-1:0]   pp_hh_s2 [NUM_TERMS];
	logic [Q_W-1:0]           term_s3 [NUM_TERMS];
	logic [Q_W-1:0]           pair_s4 [3];
	logic [Q_W-1:0]           q_s5;
	side_t                    side_s1, side_s2, side_s3, side_s4, side_s5;

	logic [WORD_W-1:0]        cl [NUM_TERMS];
	logic [WORD_W:0]          ch [NUM_TERMS];
	logic [WORD_W-1:0]        pl [NUM_TERMS];
	logic [WORD_W-1:0]        ph [NUM_TERMS];
	logic [Q_W-1:0]           term_nx [NUM_TERMS];

	always_comb begin
		for (int k = 0; k < NUM_TERMS; k++) begin
			cl[k] = cof[k][WORD_W-1:0];
			ch[k] = cof[k][COF_W-1:WORD_W];
			pl[k] = prod_s1[k][WORD_W-1:0];
			ph[k] = prod_s1[k][PROD_W-1:WORD_W];
		end
	end

	always_comb begin
		logic [Q_W-1:0] e_ll, e_lh, e_hl, e_hh, sum;
		for (int k = 0; k < NUM_TERMS; k++) begin
			e_ll = {{(Q_W - PROD_W){1'b0}}, pp_ll_s2[k]};
			e_lh = {{(Q_W - PP_W){pp_lh_s2[k][PP_W-1]}}, pp_lh_s2[k]};
			e_hl = {{(Q_W - PP_W){pp_hl_s2[k][PP_W-1]}}, pp_hl_s2[k]};
			e_hh = {{(Q_W - PP_W){pp_hh_s2[k][PP_W-1]}}, pp_hh_s2[k]};
			sum  = e_ll + (e_lh << WORD_W) + (e_hl << WORD_W) + (e_hh << (2 * WORD_W));
			term_nx[k] = TERM_DOUBLE[k] ? (sum << 1) : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0] <= dx * dx;
			prod_s1[1] <= dx * dy;
			prod_s1[2] <= dx * dz;
			prod_s1[3] <= dy * dy;
			prod_s1[4] <= dy * dz;
			prod_s1[5] <= dz * dz;
			for (int k = 0; k < NUM_TERMS; k++) begin
				pp_ll_s2[k] <= cl[k] * pl[k];
				pp_lh_s2[k] <= $signed({1'b0, cl[k]}) * $signed(ph[k]);
				pp_hl_s2[k] <= $signed(ch[k]) * $signed({1'b0, pl[k]});
				pp_hh_s2[k] <= $signed(ch[k]) * $signed(ph[k]);
				term_s3[k]  <= term_nx[k];
			end
			pair_s4[0] <= term_s3[0] + term_s3[1];
			pair_s4[1] <= term_s3[2] + term_s3[3];
			pair_s4[2] <= term_s3[4] + term_s3[5];
			q_s5       <= pair_s4[0] + pair_s4[1] + pair_s4[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (adv) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	assign q        = q_s5;
	assign side_out = side_s5;

endmodule

// ===== src/mdist_div_cell.sv =====
// One restoring-division cell: bring down one numerator bit, subtract the
// determinant if it fits, shift the quotient bit in. Depends on mdist_pkg.
module mdist_div_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [mdist_pkg::DET_W-1:0]     det,
	input  logic [mdist_pkg::DET_W-1:0]     rem_in,
	input  logic [2*mdist_pkg::WORD_W-1:0]  bits_in,
	input  mdist_pkg::side_t                side_in,
	output logic [mdist_pkg::DET_W-1:0]     rem_out,
	output logic [2*mdist_pkg::WORD_W-1:0]  bits_out,
	output mdist_pkg::side_t                side_out
);
	import mdist_pkg::*;

	logic [DET_W:0]          trial, diff;
	logic                    ge;
	logic [DET_W-1:0]        rem_s1;
	logic [2*WORD_W-1:0]     bits_s1;
	side_t                   side_s1;

	always_comb begin
		trial = {rem_in, bits_in[2*WORD_W-1]};
		diff  = trial - {1'b0, det};
		ge    = (trial >= {1'b0, det});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1  <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
			bits_s1 <= {bits_in[2*WORD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s1 <= '0;
		else if (adv)
			side_s1 <= side_in;
	end

	assign rem_out  = rem_s1;
	assign bits_out = bits_s1;
	assign side_out = side_s1;

endmodule

// ===== src/mdist_sqrt_cell.sv =====
// One digit-by-digit integer square root cell: take two radicand bits, try
// root*4+1, keep one root bit. Depends on mdist_pkg.
module mdist_sqrt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [2*mdist_pkg::WORD_W-1:0]  rad_in,
	input  logic [mdist_pkg::WORD_W+1:0]    rem_in,
	input  logic [mdist_pkg::WORD_W-1:0]    root_in,
	input  mdist_pkg::side_t                side_in,
	output logic [2*mdist_pkg::WORD_W-1:0]  rad_out,
	output logic [mdist_pkg::WORD_W+1:0]    rem_out,
	output logic [mdist_pkg::WORD_W-1:0]    root_out,
	output mdist_pkg::side_t                side_out
);
	import mdist_pkg::*;

	logic [WORD_W+1:0]   rr, trial;
	logic                ge;
	logic [2*WORD_W-1:0] rad_s1;
	logic [WORD_W+1:0]   rem_s1;
	logic [WORD_W-1:0]   root_s1;
	side_t               side_s1;

	always_comb begin
		rr    = {rem_in[WORD_W-1:0], rad_in[2*WORD_W-1:2*WORD_W-2]};
		trial = {root_in, 2'b01};
		ge    = (rr >= trial);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1  <= {rad_in[2*WORD_W-3:0], 2'b00};
			rem_s1  <= ge ? rr - trial : rr;
			root_s1 <= {root_in[WORD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s1 <= '0;
		else if (adv)
			side_s1 <= side_in;
	end

	assign rad_out  = rad_s1;
	assign rem_out  = rem_s1;
	assign root_out = root_s1;
	assign side_out = side_s1;

endmodule

// ===== src/mahalanobis_distance_3d_unit.sv =====
// Top level of the 3D Mahalanobis distance unit: covariance solver, quadratic
// form pipeline, division and square-root cell chains. Depends on mdist_pkg.
//
// Streams one separation vector (Q16.16) per cycle while in_ready is high and
// returns floor(sqrt(floor(Q * 2^16 / det))) per request, with Q = d' adj(S) d,
// saturated to all ones and forced to 0 on a negative Q or a failed covariance
// check. Throughput is one request per clock while in_ready is high. From
// acceptance to out_valid a request passes five quadratic-form stages
// (33x33 partial products), one divider entry stage, a chain of 64 division
// cells, a chain of 32 square-root cells and the output register. The
// cofactors, determinant and status are derived once, by a bit-serial
// multiply-accumulate sequencer, after reset and after every register write:
// 15 products and then a check step, during which in_ready stays low. The
// pipeline moves as a whole: it stalls only while a result sits in the output
// register and out_ready is low. status reports the first failed check on the
// covariance (determinant at most 1e-10, var_x not positive, leading minor
// not positive) and is the same for every result until the next write.
module mahalanobis_distance_3d_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mdist_pkg::WORD_W-1:0] delta_x,
	input  logic signed [mdist_pkg::WORD_W-1:0] delta_y,
	input  logic signed [mdist_pkg::WORD_W-1:0] delta_z,
	input  logic                                last_pair,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mdist_pkg::WORD_W-1:0]        distance,
	output logic [1:0]                          status,
	output logic                                last_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mdist_pkg::IDX_W-1:0]         cfg_index,
	input  logic [mdist_pkg::WORD_W-1:0]        cfg_data
);
	import mdist_pkg::*;

	localparam int DIV_CELLS  = 2 * WORD_W;
	localparam int SQRT_CELLS = WORD_W;
	localparam int NLO_W      = 2 * WORD_W - FRAC_W;

	cov_t              cov;
	logic              adv;
	side_t             in_side;
	logic [Q_W-1:0]    q_s5;
	side_t             side_s5;

	logic [NH_W-1:0]   q_high;
	logic [DET_W-1:0]  rem_s6;
	logic [2*WORD_W-1:0] bits_s6;
	side_t             side_s6;

	logic [DET_W-1:0]    div_rem  [DIV_CELLS+1];
	logic [2*WORD_W-1:0] div_bits [DIV_CELLS+1];
	side_t               div_side [DIV_CELLS+1];

	logic [2*WORD_W-1:0] sq_rad  [SQRT_CELLS+1];
	logic [WORD_W+1:0]   sq_rem  [SQRT_CELLS+1];
	logic [WORD_W-1:0]   sq_root [SQRT_CELLS+1];
	side_t               sq_side [SQRT_CELLS+1];

	logic                out_valid_q;
	logic [WORD_W-1:0]   distance_q;
	logic [1:0]          status_q;
	logic                last_q;

	// Advance the whole pipeline unless a result waits in the output register with out_ready low.
	assign adv      = !out_valid_q || out_ready;
	// Hold off new requests while the covariance is being derived.
	assign in_ready = adv && !cov.busy;

	assign in_side.valid = in_valid && in_ready;
	assign in_side.last  = last_pair;
	assign in_side.neg   = 1'b0;
	assign in_side.sat   = 1'b0;

	mdist_cov_solver u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cov       (cov)
	);

	mdist_quad_form u_quad (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.side_in  (in_side),
		.dx       (delta_x),
		.dy       (delta_y),
		.dz       (delta_z),
		.cof      (cov.cof),
		.q        (q_s5),
		.side_out (side_s5)
	);

	// Divider entry: the numerator is Q * 2^FRAC_W. Its part above the 2*WORD_W
	// quotient bits seeds the remainder; a quotient of 2^(2*WORD_W) or more
	// shows up as that part reaching the determinant, which saturates.
	assign q_high = q_s5[Q_W-1:NLO_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s6  <= {{(DET_W - NH_W){1'b0}}, q_high};
			bits_s6 <= {q_s5[NLO_W-1:0], {FRAC_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else if (adv) begin
			side_s6.valid <= side_s5.valid;
			side_s6.last  <= side_s5.last;
			side_s6.neg   <= q_s5[Q_W-1];
			side_s6.sat   <= ({{(DET_W - NH_W){1'b0}}, q_high} >= cov.det);
		end
	end

	assign div_rem[0]  = rem_s6;
	assign div_bits[0] = bits_s6;
	assign div_side[0] = side_s6;

	// One quotient bit per cell, most significant first.
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		mdist_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.det      (cov.det),
			.rem_in   (div_rem[i]),
			.bits_in  (div_bits[i]),
			.side_in  (div_side[i]),
			.rem_out  (div_rem[i+1]),
			.bits_out (div_bits[i+1]),
			.side_out (div_side[i+1])
		);
	end

	assign sq_rad[0]  = div_bits[DIV_CELLS];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = div_side[DIV_CELLS];

	// One root bit per cell, most significant first.
	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		mdist_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.rad_in   (sq_rad[j]),
			.rem_in   (sq_rem[j]),
			.root_in  (sq_root[j]),
			.side_in  (sq_side[j]),
			.rad_out  (sq_rad[j+1]),
			.rem_out  (sq_rem[j+1]),
			.root_out (sq_root[j+1]),
			.side_out (sq_side[j+1])
		);
	end

	// Output register: drop the distance to 0 on a failed check or a
	// negative form, clamp to all ones on overflow.
	always_ff @(posedge clk) begin
		if (adv) begin
			last_q   <= sq_side[SQRT_CELLS].last;
			status_q <= cov.status;
			if (cov.status != ST_OK || sq_side[SQRT_CELLS].neg)
				distance_q <= '0;
			else if (sq_side[SQRT_CELLS].sat)
				distance_q <= '1;
			else
				distance_q <= sq_root[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= sq_side[SQRT_CELLS].valid;
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign status    = status_q;
	assign last_out  = last_q;

endmodule

// ===== tb/mahalanobis_distance_3d_unit_tb.sv =====
// Self-checking testbench for the 3D Mahalanobis distance unit.
// Depends on mdist_pkg and mahalanobis_distance_3d_unit from src.
// Predicts every distance and status with wide integer math and checks results in order.
module mahalanobis_distance_3d_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mdist_pkg::*;

	// Indexes past the last register; the block must ignore writes to them
	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int PIPE_LAT = 103;
	localparam int FLUSH_CYC = PIPE_LAT + 20;

	typedef logic signed [255:0] wint_t;

	typedef struct {
		logic [WORD_W-1:0] distance;
		status_t           status;
		logic              last;
	} dist_exp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [WORD_W-1:0] delta_x = '0;
	logic signed [WORD_W-1:0] delta_y = '0;
	logic signed [WORD_W-1:0] delta_z = '0;
	logic                     last_pair = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [WORD_W-1:0]        distance;
	logic [1:0]               status;
	logic                     last_out;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [WORD_W-1:0]        cfg_data = '0;

	// Shadow copy of the covariance registers, in register index order
	logic [WORD_W-1:0] cov_shadow [0:5];
	dist_exp_t         pending_dist_q [$];
	int                err_cnt = 0;
	int                sender_idle_pct = 0;
	int                receiver_idle_pct = 0;

	mahalanobis_distance_3d_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.delta_z   (delta_z),
		.last_pair (last_pair),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance),
		.status    (status),
		.last_out  (last_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Compute distance and status for one separation vector under the shadow covariance.
	// Every intermediate is exact in 256 bits, so no rounding happens before the divide.
	function automatic dist_exp_t mdist_predict(input logic [WORD_W-1:0] dx,
			input logic [WORD_W-1:0] dy, input logic [WORD_W-1:0] dz, input logic last);
		wint_t a, b, c, d, e, f, x, y, z;
		wint_t det, minor, c11, c12, c13, c22, c23, q, r, root, cand;
		dist_exp_t res;
		a = wint_t'($signed(cov_shadow[REG_VAR_X]));
		b = wint_t'($signed(cov_shadow[REG_COV_XY]));
		c = wint_t'($signed(cov_shadow[REG_COV_XZ]));
		d = wint_t'($signed(cov_shadow[REG_VAR_Y]));
		e = wint_t'($signed(cov_shadow[REG_COV_YZ]));
		f = wint_t'($signed(cov_shadow[REG_VAR_Z]));
		x = wint_t'($signed(dx));
		y = wint_t'($signed(dy));
		z = wint_t'($signed(dz));
		res.distance = '0;
		res.status = ST_OK;
		res.last = last;
		det = a * d * f - b * b * f - a * e * e + 2 * b * c * e - c * c * d;
		minor = a * d - b * b;
		// Check order matters: determinant first, then var_x, then the 2x2 minor
		if (det * wint_t'(64'd10000000000) <= (wint_t'(1) <<< (3 * FRAC_W))) begin
			res.status = ST_DET_SMALL;
		end else if (a <= 0) begin
			res.status = ST_VAR_X;
		end else if (minor <= 0) begin
			res.status = ST_MINOR;
		end else begin
			c11 = d * f - e * e;
			c12 = c * e - b * f;
			c13 = b * e - c * d;
			c22 = a * f - c * c;
			c23 = b * c - a * e;
			q = c11 * x * x + 2 * c12 * x * y + 2 * c13 * x * z + c22 * y * y
				+ 2 * c23 * y * z + minor * z * z;
			// A negative form clamps the distance to zero
			if (q >= 0) begin
				r = (q <<< FRAC_W) / det;
				if (r >= (wint_t'(1) <<< (2 * WORD_W))) begin
					res.distance = '1;
				end else begin
					root = 0;
					for (int i = WORD_W - 1; i >= 0; i--) begin
						cand = root | (wint_t'(1) <<< i);
						if (cand * cand <= r)
							root = cand;
					end
					res.distance = root[WORD_W-1:0];
				end
			end
		end
		return res;
	endfunction

	// Receiver: randomly hold off out_ready at the configured rate
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Compare every accepted result against the oldest pending expectation
	always @(posedge clk) begin
		dist_exp_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dist_q.size() == 0) begin
				$display("%0t: unexpected result distance=%h status=%0d last=%b",
					$time, distance, status, last_out);
				err_cnt++;
			end else begin
				exp_res = pending_dist_q.pop_front();
				if (distance !== exp_res.distance) begin
					$display("%0t: distance mismatch expected %h actual %h",
						$time, exp_res.distance, distance);
					err_cnt++;
				end
				if (status !== exp_res.status) begin
					$display("%0t: status mismatch expected %0d actual %0d",
						$time, exp_res.status, status);
					err_cnt++;
				end
				if (last_out !== exp_res.last) begin
					$display("%0t: last_out mismatch expected %b actual %b",
						$time, exp_res.last, last_out);
					err_cnt++;
				end
			end
		end
	end

	// Send one request; idle before it at the sender rate, hold until accepted
	task automatic send_pair(input logic [WORD_W-1:0] dx, input logic [WORD_W-1:0] dy,
			input logic [WORD_W-1:0] dz, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		delta_x   <= dx;
		delta_y   <= dy;
		delta_z   <= dz;
		last_pair <= last;
		do @(posedge clk); while (!in_ready);
		pending_dist_q.push_back(mdist_predict(dx, dy, dz, last));
	endtask

	// Wait for every pending result, then let the pipeline settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_dist_q.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_VAR_Z)
			cov_shadow[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_cov(input logic [WORD_W-1:0] vx, input logic [WORD_W-1:0] cxy,
			input logic [WORD_W-1:0] cxz, input logic [WORD_W-1:0] vy,
			input logic [WORD_W-1:0] cyz, input logic [WORD_W-1:0] vz);
		drain_results();
		write_reg(REG_VAR_X, vx);
		write_reg(REG_COV_XY, cxy);
		write_reg(REG_COV_XZ, cxz);
		write_reg(REG_VAR_Y, vy);
		write_reg(REG_COV_YZ, cyz);
		write_reg(REG_VAR_Z, vz);
	endtask

	// Random field: mostly moderate magnitudes, sometimes the full range
	function automatic logic [WORD_W-1:0] rand_delta();
		logic [WORD_W-1:0] v;
		if ($urandom_range(3) == 0)
			v = $urandom;
		else
			v = WORD_W'($signed($urandom_range(1 << 22)) - (1 << 21));
		return v;
	endfunction

	task automatic send_rand_pairs(input int n);
		for (int i = 0; i < n; i++)
			send_pair(rand_delta(), rand_delta(), rand_delta(), 1'($urandom_range(1)));
	endtask

	// Positive definite covariance: strong diagonal, small off-diagonal terms
	task automatic write_rand_pd_cov();
		logic [WORD_W-1:0] vx, vy, vz;
		vx = $urandom_range(32'h0010_0000, 32'h0000_1000);
		vy = $urandom_range(32'h0010_0000, 32'h0000_1000);
		vz = $urandom_range(32'h0010_0000, 32'h0000_1000);
		write_cov(vx, WORD_W'($signed($urandom_range(1024)) - 512),
			WORD_W'($signed($urandom_range(1024)) - 512), vy,
			WORD_W'($signed($urandom_range(1024)) - 512), vz);
	endtask

	// Reset values give the identity, so distance is the Euclidean norm
	task automatic test_reset_identity();
		send_pair('0, '0, '0, 1'b0);
		send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_pair(32'h7fff_ffff, 32'h8000_0000, '0, 1'b1);
		send_pair(COV_ONE, '0, '0, 1'b0);
		send_pair('0, COV_ONE, '0, 1'b0);
		send_pair('0, '0, COV_ONE, 1'b1);
		send_pair(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b0);
	endtask

	// Tiny diagonal variances push the ratio past the output range for large separations
	task automatic test_saturation();
		write_cov(32'h1000, '0, '0, 32'h1000, '0, 32'h1000);
		send_pair(32'h7fff_ffff, '0, '0, 1'b0);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_pair(32'h0000_0001, '0, '0, 1'b0);
	endtask

	// Each failing covariance check, in its priority order, plus the spare indexes and extreme register values
	task automatic test_config_checks();
		write_cov('0, '0, '0, COV_ONE, '0, COV_ONE);
		send_pair(COV_ONE, COV_ONE, COV_ONE, 1'b1);
		write_cov(-COV_ONE, '0, '0, -COV_ONE, '0, COV_ONE);
		send_pair(COV_ONE, '0, '0, 1'b0);
		write_cov(COV_ONE, '0, '0, -COV_ONE, '0, -COV_ONE);
		send_pair(COV_ONE, '0, 32'h8000_0000, 1'b1);
		drain_results();
		write_reg(REG_SPARE_6, 32'h0000_0000);
		write_reg(REG_SPARE_7, 32'hffff_ffff);
		send_pair(COV_ONE, COV_ONE, '0, 1'b0);
		write_cov(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 1'b0);
		write_cov(32'h7fff_ffff, '0, '0, 32'h7fff_ffff, '0, 32'h7fff_ffff);
		send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		send_pair(32'h0000_0001, '0, '0, 1'b0);
	endtask

	// Random traffic under the three idling schemes, changing the covariance between chunks
	task automatic test_random_traffic();
		for (int mode = 0; mode < 3; mode++) begin
			sender_idle_pct   = (mode == 0) ? 12 : (mode == 1) ? 72 : 0;
			receiver_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 12 : 0;
			write_rand_pd_cov();
			send_rand_pairs(60);
			// Full-range random covariance: mostly failing checks, all bits exercised
			write_cov($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			send_rand_pairs(30);
			write_rand_pd_cov();
			send_rand_pairs(60);
		end
	endtask

	initial begin
		for (int i = 0; i <= REG_VAR_Z; i++)
			cov_shadow[i] = (i == REG_VAR_X || i == REG_VAR_Y || i == REG_VAR_Z) ? COV_ONE : '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct   = 12;
		receiver_idle_pct = 72;
		test_reset_identity();
		test_saturation();
		test_config_checks();
		test_random_traffic();
		drain_results();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
